// ===== rtl/ccss_pkg.sv =====
// Shared types, codes and constants of the Collatz coefficient stopping scan.
package ccss_pkg;

    // Field widths
    localparam int CandW    = 64;
    localparam int TallyW   = 64;
    localparam int StepOutW = 12;
    localparam logic [StepOutW-1:0] StepMax = 12'd4095;

    // log3(2) as an unsigned 0.40 fixed-point fraction, truncated
    localparam int FracW = 40;
    localparam logic [FracW-1:0] LogRatio = 40'd693714600361;

    // Width of the walk value: guard limit plus room for one 3/2 step
    localparam int ValW = 128;

    // Queue between front and walker
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = 1;

    typedef enum logic [2:0] {
        VERDICT_HOLDS    = 3'd0,
        VERDICT_BAD      = 3'd1,
        VERDICT_HEADROOM = 3'd2,
        VERDICT_LENGTH   = 3'd3,
        VERDICT_SKIPPED  = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        WALK_IDLE,
        WALK_STEP,
        WALK_DONE
    } walk_state_t;

    // Classified candidate travelling from front to walker
    typedef struct packed {
        logic [CandW-1:0] n;
        logic             below_two;
    } job_t;

    // Finished walk travelling from walker to tally stage
    typedef struct packed {
        verdict_t            verdict;
        logic [StepOutW-1:0] stop;
    } outcome_t;

endpackage

// ===== rtl/ccss_if.sv =====
// Valid/ready channel interfaces for candidate words and result words.
interface ccss_cand_if;
    logic                      valid;
    logic                      ready;
    logic [ccss_pkg::CandW-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface ccss_res_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   verdict;
    logic [ccss_pkg::StepOutW-1:0] stop_step;
    logic [ccss_pkg::TallyW-1:0]   total_bad;
    logic [ccss_pkg::CandW-1:0]    earliest_bad;
    logic [ccss_pkg::StepOutW-1:0] largest_stop;
    logic [ccss_pkg::TallyW-1:0]   total_skip_headroom;
    logic [ccss_pkg::TallyW-1:0]   total_skip_length;

    modport source (output valid, output verdict, output stop_step, output total_bad,
                    output earliest_bad, output largest_stop, output total_skip_headroom,
                    output total_skip_length, input ready);
    modport sink   (input valid, input verdict, input stop_step, input total_bad,
                    input earliest_bad, input largest_stop, input total_skip_headroom,
                    input total_skip_length, output ready);
endinterface

// ===== rtl/ccss_front.sv =====
// Front stage: takes candidate words and classifies them for the walker.
module ccss_front (
    input  logic            clk,
    input  logic            rst_n,
    ccss_cand_if.sink       candidates,
    output ccss_pkg::job_t  job,
    output logic            job_valid,
    input  logic            job_ready
);

    logic           full_reg;
    ccss_pkg::job_t job_reg;
    logic           take;

    // Accept a new word whenever the holding register is empty or draining
    assign candidates.ready = !full_reg || job_ready;
    assign take             = candidates.valid && candidates.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (candidates.ready)
        begin
            full_reg <= candidates.valid;
        end
    end

    // Hold the candidate and mark the ones below two
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg.n         <= candidates.candidate;
            job_reg.below_two <= (candidates.candidate < 64'd2);
        end
    end

    assign job       = job_reg;
    assign job_valid = full_reg;

endmodule

// ===== rtl/ccss_queue.sv =====
// Short queue that decouples the front stage from the walker.
module ccss_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  ccss_pkg::job_t  push_job,
    input  logic            push_valid,
    output logic            push_ready,
    output ccss_pkg::job_t  pop_job,
    output logic            pop_valid,
    input  logic            pop
);

    ccss_pkg::job_t                 slot_reg [ccss_pkg::QueueDepth];
    logic [ccss_pkg::QueuePtrW-1:0] wr_ptr_reg;
    logic [ccss_pkg::QueuePtrW-1:0] rd_ptr_reg;
    logic [ccss_pkg::QueuePtrW:0]   count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (count_reg != (ccss_pkg::QueuePtrW+1)'(ccss_pkg::QueueDepth));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_job    = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (ccss_pkg::QueuePtrW+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (ccss_pkg::QueuePtrW+1)'(1);
            end
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/ccss_walker.sv =====
// Walker: runs the shortcut map one step a cycle until the walk is decided, passes the guard or reaches the step limit.
module ccss_walker #(
    parameter int MAX_STEPS  = 4096,
    parameter int GUARD_BITS = 120
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ccss_pkg::job_t     job,
    input  logic               job_valid,
    output logic               job_pop,
    output ccss_pkg::outcome_t outcome,
    output logic [ccss_pkg::CandW-1:0] outcome_n,
    output logic               outcome_valid,
    input  logic               outcome_ready
);

    localparam int StepW = $clog2(MAX_STEPS);
    localparam int AccW  = StepW + ccss_pkg::FracW;
    localparam int ValW  = ccss_pkg::ValW;

    ccss_pkg::walk_state_t       state_reg, state_next;
    logic [ValW-1:0]             val_reg, val_next;
    logic [ccss_pkg::CandW-1:0]  n_reg, n_next;
    logic [StepW-1:0]            k_reg, k_next;
    logic [StepW-1:0]            step_reg, step_next;
    logic [AccW-1:0]             acc_reg, acc_next;
    ccss_pkg::outcome_t          res_reg, res_next;

    logic [ValW-1:0]             val_step;
    logic [StepW-1:0]            k_step;
    logic [AccW-1:0]             acc_step;
    logic                        decided;
    logic                        over_guard;
    logic                        reach_n;
    logic                        last_step;
    logic [31:0]                 step_wide;
    logic [ccss_pkg::StepOutW-1:0] stop_sat;

    // One map step: v/2 for even v, v + v/2 + 1 for odd v
    always_comb
    begin
        if (val_reg[0])
        begin
            val_step = val_reg + (val_reg >> 1) + ValW'(1);
        end
        else
        begin
            val_step = val_reg >> 1;
        end
    end

    // Odd-step count against floor(L*log3(2)); k below the ceiling means k is at most the floor
    assign k_step     = k_reg + StepW'(val_reg[0]);
    assign acc_step   = acc_reg + AccW'(ccss_pkg::LogRatio);
    assign decided    = (k_step <= acc_step[AccW-1 -: StepW]);
    assign over_guard = ((val_step >> GUARD_BITS) != '0);
    assign reach_n    = (val_step >= {{(ValW-ccss_pkg::CandW){1'b0}}, n_reg});
    assign last_step  = (step_reg == StepW'(MAX_STEPS - 1));

    // Clip the step number to the twelve-bit report field
    assign step_wide = 32'(step_reg);
    assign stop_sat  = (step_wide > 32'(ccss_pkg::StepMax)) ? ccss_pkg::StepMax
                                                            : step_wide[ccss_pkg::StepOutW-1:0];

    // Sequence the walk
    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        job_pop    = 1'b0;

        unique case (state_reg)
            ccss_pkg::WALK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop   = 1'b1;
                    n_next    = job.n;
                    val_next  = {{(ValW-ccss_pkg::CandW){1'b0}}, job.n};
                    k_next    = '0;
                    step_next = StepW'(1);
                    acc_next  = '0;
                    if (job.below_two)
                    begin
                        res_next.verdict = ccss_pkg::VERDICT_SKIPPED;
                        res_next.stop    = '0;
                        state_next       = ccss_pkg::WALK_DONE;
                    end
                    else
                    begin
                        state_next = ccss_pkg::WALK_STEP;
                    end
                end
            end

            ccss_pkg::WALK_STEP:
            begin
                val_next = val_step;
                k_next   = k_step;
                acc_next = acc_step;
                priority if (decided)
                begin
                    res_next.verdict = reach_n ? ccss_pkg::VERDICT_BAD : ccss_pkg::VERDICT_HOLDS;
                    res_next.stop    = stop_sat;
                    state_next       = ccss_pkg::WALK_DONE;
                end
                else if (over_guard)
                begin
                    res_next.verdict = ccss_pkg::VERDICT_HEADROOM;
                    res_next.stop    = '0;
                    state_next       = ccss_pkg::WALK_DONE;
                end
                else if (last_step)
                begin
                    res_next.verdict = ccss_pkg::VERDICT_LENGTH;
                    res_next.stop    = '0;
                    state_next       = ccss_pkg::WALK_DONE;
                end
                else
                begin
                    step_next = step_reg + StepW'(1);
                end
            end

            ccss_pkg::WALK_DONE:
            begin
                if (outcome_ready)
                begin
                    state_next = ccss_pkg::WALK_IDLE;
                end
            end

            default:
            begin
                state_next = ccss_pkg::WALK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ccss_pkg::WALK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Walk datapath registers
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        step_reg <= step_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    assign outcome       = res_reg;
    assign outcome_n     = n_reg;
    assign outcome_valid = (state_reg == ccss_pkg::WALK_DONE);

endmodule

// ===== rtl/ccss_tally.sv =====
// Tally stage: keeps the running totals and holds the result word for the receiver.
module ccss_tally (
    input  logic               clk,
    input  logic               rst_n,
    input  ccss_pkg::outcome_t outcome,
    input  logic [ccss_pkg::CandW-1:0] outcome_n,
    input  logic               outcome_valid,
    output logic               outcome_ready,
    ccss_res_if.source         results
);

    logic                          out_valid_reg;
    ccss_pkg::verdict_t            verdict_reg;
    logic [ccss_pkg::StepOutW-1:0] stop_reg;
    logic [ccss_pkg::TallyW-1:0]   bad_reg, bad_next;
    logic [ccss_pkg::CandW-1:0]    first_reg, first_next;
    logic [ccss_pkg::StepOutW-1:0] max_reg, max_next;
    logic [ccss_pkg::TallyW-1:0]   head_reg, head_next;
    logic [ccss_pkg::TallyW-1:0]   len_reg, len_next;
    logic                          take;

    assign outcome_ready = !out_valid_reg || results.ready;
    assign take          = outcome_valid && outcome_ready;

    // Update the totals for the word being taken; totals stop at all ones
    always_comb
    begin
        bad_next   = bad_reg;
        first_next = first_reg;
        max_next   = max_reg;
        head_next  = head_reg;
        len_next   = len_reg;
        if (outcome.stop > max_reg)
        begin
            max_next = outcome.stop;
        end
        unique case (outcome.verdict)
            ccss_pkg::VERDICT_BAD:
            begin
                if (bad_reg != '1)
                begin
                    bad_next = bad_reg + ccss_pkg::TallyW'(1);
                end
                if (first_reg == '0)
                begin
                    first_next = outcome_n;
                end
            end
            ccss_pkg::VERDICT_HEADROOM:
            begin
                if (head_reg != '1)
                begin
                    head_next = head_reg + ccss_pkg::TallyW'(1);
                end
            end
            ccss_pkg::VERDICT_LENGTH:
            begin
                if (len_reg != '1)
                begin
                    len_next = len_reg + ccss_pkg::TallyW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            bad_reg       <= '0;
            first_reg     <= '0;
            max_reg       <= '0;
            head_reg      <= '0;
            len_reg       <= '0;
        end
        else
        begin
            if (outcome_ready)
            begin
                out_valid_reg <= outcome_valid;
            end
            if (take)
            begin
                bad_reg   <= bad_next;
                first_reg <= first_next;
                max_reg   <= max_next;
                head_reg  <= head_next;
                len_reg   <= len_next;
            end
        end
    end

    // Hold the per-item fields of the result word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            verdict_reg <= outcome.verdict;
            stop_reg    <= outcome.stop;
        end
    end

    assign results.valid               = out_valid_reg;
    assign results.verdict             = verdict_reg;
    assign results.stop_step           = stop_reg;
    assign results.total_bad           = bad_reg;
    assign results.earliest_bad        = first_reg;
    assign results.largest_stop        = max_reg;
    assign results.total_skip_headroom = head_reg;
    assign results.total_skip_length   = len_reg;

endmodule

// ===== rtl/collatz_coefficient_stopping_scan.sv =====
// Collatz coefficient stopping scan: one candidate word in, one result word out.
//
// Usage: each word on the candidates channel is one 64-bit n. For every candidate
// the block returns exactly one word on the results channel, in order, carrying the
// verdict, the stop step and the running totals as they stand after that candidate.
// Path: a candidate passes the front register and the two-entry queue, then the
// walker loads it, runs S map steps at one step a cycle and hands the result to
// the output register. S is the step at which the walk is decided, between 1 and
// MAX_STEPS-1; most candidates decide in one to three steps. Candidates below two
// skip the walk. The walker has a single 128-bit map-step unit and takes a new
// candidate only after it has handed its last result on.
// The front and queue keep taking candidates while the walker is busy, and the
// output register lets the walker finish the next item while a result waits.
// Reset clears all totals, the queue and the walker; the first result word follows
// the first accepted candidate. When the receiver holds ready low the result stays
// stable, the walker waits with its finished result and the queue fills, after
// which the candidates channel drops ready.
module collatz_coefficient_stopping_scan #(
    parameter int MAX_STEPS  = 4096,
    parameter int GUARD_BITS = 120
) (
    input  logic       clk,
    input  logic       rst_n,
    ccss_cand_if.sink  candidates,
    ccss_res_if.source results
);

    ccss_pkg::job_t             front_job;
    logic                       front_valid;
    logic                       front_ready;
    ccss_pkg::job_t             head_job;
    logic                       head_valid;
    logic                       head_pop;
    ccss_pkg::outcome_t         outcome;
    logic [ccss_pkg::CandW-1:0] outcome_n;
    logic                       outcome_valid;
    logic                       outcome_ready;

    // Accept and classify
    ccss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .candidates (candidates),
        .job        (front_job),
        .job_valid  (front_valid),
        .job_ready  (front_ready)
    );

    // Decouple front and walker
    ccss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (front_job),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_job    (head_job),
        .pop_valid  (head_valid),
        .pop        (head_pop)
    );

    // Run the map
    ccss_walker #(
        .MAX_STEPS  (MAX_STEPS),
        .GUARD_BITS (GUARD_BITS)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (head_job),
        .job_valid     (head_valid),
        .job_pop       (head_pop),
        .outcome       (outcome),
        .outcome_n     (outcome_n),
        .outcome_valid (outcome_valid),
        .outcome_ready (outcome_ready)
    );

    // Keep totals and present the result word; the walker still holds n while done
    ccss_tally u_tally (
        .clk           (clk),
        .rst_n         (rst_n),
        .outcome       (outcome),
        .outcome_n     (outcome_n),
        .outcome_valid (outcome_valid),
        .outcome_ready (outcome_ready),
        .results       (results)
    );

endmodule

// ===== test/collatz_coefficient_stopping_scan_tb.sv =====
// Self-checking testbench for the Collatz stopping scan: table-driven and random words.
module collatz_coefficient_stopping_scan_tb;

    localparam int MAX_STEPS    = 4096;
    localparam int GUARD_BITS   = 120;
    localparam int RANDOM_WORDS = 1550;
    localparam int GAP_MAX      = 8;
    localparam int DRAIN_CYCLES = 64;
    localparam int TABLE_ROWS   = 22;
    localparam int CandW        = ccss_pkg::CandW;
    localparam int TallyW       = ccss_pkg::TallyW;
    localparam int StepOutW     = ccss_pkg::StepOutW;
    localparam int ValW         = ccss_pkg::ValW;
    localparam logic [StepOutW-1:0] StepMax = ccss_pkg::StepMax;
    // Every word taking the longest walk, the longest gap and a long receiver stall
    localparam longint CYCLE_LIMIT =
        longint'(RANDOM_WORDS + TABLE_ROWS) * longint'(MAX_STEPS + 4 * GAP_MAX + 256) * 3;

    typedef struct packed {
        ccss_pkg::verdict_t  verdict;
        logic [StepOutW-1:0] stop;
        logic [TallyW-1:0]   bad_count;
        logic [CandW-1:0]    first_bad;
        logic [StepOutW-1:0] top_stop;
        logic [TallyW-1:0]   headroom_count;
        logic [TallyW-1:0]   length_count;
    } scan_result_t;

    // One row of the directed table; typed rows carry a verdict and stop step read off by hand
    typedef struct packed {
        logic [CandW-1:0]    n;
        logic                typed;
        ccss_pkg::verdict_t  verdict;
        logic [StepOutW-1:0] stop;
    } table_row_t;

    logic clk;
    logic rst_n;

    ccss_cand_if cand_ch ();
    ccss_res_if  res_ch ();

    collatz_coefficient_stopping_scan #(
        .MAX_STEPS  (MAX_STEPS),
        .GUARD_BITS (GUARD_BITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .candidates (cand_ch),
        .results    (res_ch)
    );

    // Running totals of the scan as the block should hold them
    logic [TallyW-1:0]   tally_bad;
    logic [CandW-1:0]    first_bad_n;
    logic [StepOutW-1:0] max_stop;
    logic [TallyW-1:0]   tally_headroom;
    logic [TallyW-1:0]   tally_length;
    int unsigned         need_tab [MAX_STEPS];

    scan_result_t pending_q [$];
    int           mismatches;
    int           words_checked;
    int           verdict_hits [5];
    int           burst_left;
    longint       cycle_count;

    table_row_t scan_table [TABLE_ROWS] = '{
        '{64'd0,                   1'b1, ccss_pkg::VERDICT_SKIPPED, 12'd0},
        '{64'd1,                   1'b1, ccss_pkg::VERDICT_SKIPPED, 12'd0},
        '{64'd2,                   1'b1, ccss_pkg::VERDICT_HOLDS,   12'd1},
        '{64'd3,                   1'b0, ccss_pkg::VERDICT_HOLDS,   12'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ccss_pkg::VERDICT_HOLDS,   12'd0},
        '{64'hFFFF_FFFF_FFFF_FFFE, 1'b1, ccss_pkg::VERDICT_HOLDS,   12'd1},
        '{64'h8000_0000_0000_0000, 1'b1, ccss_pkg::VERDICT_HOLDS,   12'd1},
        '{64'h8000_0000_0000_0001, 1'b0, ccss_pkg::VERDICT_HOLDS,   12'd0},
        '{64'd27,                  1'b0, ccss_pkg::VERDICT_HOLDS,   12'd0},
        '{64'd7,                   1'b0, ccss_pkg::VERDICT_HOLDS,   12'd0},
        '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, ccss_pkg::VERDICT_HOLDS,   12'd0},
        '{64'h5555_5555_5555_5555, 1'b0, ccss_pkg::VERDICT_HOLDS,   12'd0},
        '{64'hAAAA_AAAA_AAAA_AAAB, 1'b0, ccss_pkg::VERDICT_HOLDS,   12'd0},
        '{64'h0000_0000_FFFF_FFFF, 1'b0, ccss_pkg::VERDICT_HOLDS,   12'd0},
        '{64'd63728127,            1'b0, ccss_pkg::VERDICT_HOLDS,   12'd0},
        '{64'd1,                   1'b1, ccss_pkg::VERDICT_SKIPPED, 12'd0},
        '{64'd0,                   1'b1, ccss_pkg::VERDICT_SKIPPED, 12'd0},
        '{64'd4,                   1'b1, ccss_pkg::VERDICT_HOLDS,   12'd1},
        '{64'hFFFF_FFFF_FFFF_FFFD, 1'b0, ccss_pkg::VERDICT_HOLDS,   12'd0},
        '{64'hFFFF_FFFF_FFFF_FFFB, 1'b0, ccss_pkg::VERDICT_HOLDS,   12'd0},
        '{64'd670617279,           1'b0, ccss_pkg::VERDICT_HOLDS,   12'd0},
        '{64'h8000_0000_0000_0003, 1'b0, ccss_pkg::VERDICT_HOLDS,   12'd0}
    };

    // need_tab[s] is the least m with 3^m >= 2^s, worked out on an exact wide integer
    function automatic void build_need_table();
        logic [MAX_STEPS+8:0] pow3;
        int unsigned          m;
        pow3 = 1;
        m = 0;
        need_tab[0] = 0;
        for (int s = 1; s < MAX_STEPS; s++)
        begin
            while ((pow3 >> s) == 0)
            begin
                pow3 = pow3 + (pow3 << 1);
                m++;
            end
            need_tab[s] = m;
        end
    endfunction

    function automatic logic [TallyW-1:0] sat_inc(input logic [TallyW-1:0] x);
        return (&x) ? x : x + 1'b1;
    endfunction

    // Walk the shortcut map on n, update the running totals and return the result word
    function automatic scan_result_t predict_scan(input logic [CandW-1:0] n);
        scan_result_t r;
        logic [ValW-1:0] v;
        int unsigned     odd_steps;
        bit              decided;
        r = '0;
        r.verdict = ccss_pkg::VERDICT_LENGTH;
        decided = 1'b0;
        odd_steps = 0;
        if (n < 2)
        begin
            r.verdict = ccss_pkg::VERDICT_SKIPPED;
        end
        else
        begin
            v = {{(ValW-CandW){1'b0}}, n};
            for (int s = 1; s < MAX_STEPS && !decided; s++)
            begin
                if (v[0])
                begin
                    v = v + (v >> 1) + 1'b1;
                    odd_steps++;
                end
                else
                begin
                    v = v >> 1;
                end
                // The odd-step test wins over the headroom guard at the same step
                if (odd_steps < need_tab[s])
                begin
                    decided = 1'b1;
                    r.stop = (s > int'(StepMax)) ? StepMax : StepOutW'(s);
                    if (r.stop > max_stop)
                        max_stop = r.stop;
                    if (v >= {{(ValW-CandW){1'b0}}, n})
                    begin
                        r.verdict = ccss_pkg::VERDICT_BAD;
                        tally_bad = sat_inc(tally_bad);
                        if (first_bad_n == 0)
                            first_bad_n = n;
                    end
                    else
                    begin
                        r.verdict = ccss_pkg::VERDICT_HOLDS;
                    end
                end
                else if ((v >> GUARD_BITS) != 0)
                begin
                    decided = 1'b1;
                    r.verdict = ccss_pkg::VERDICT_HEADROOM;
                    tally_headroom = sat_inc(tally_headroom);
                end
            end
            if (!decided)
                tally_length = sat_inc(tally_length);
        end
        r.bad_count      = tally_bad;
        r.first_bad      = first_bad_n;
        r.top_stop       = max_stop;
        r.headroom_count = tally_headroom;
        r.length_count   = tally_length;
        return r;
    endfunction

    // Offer one candidate word in bursts with random gaps; predict it once accepted
    task automatic send_word(input logic [CandW-1:0] n, input logic typed,
                             input ccss_pkg::verdict_t typed_verdict,
                             input logic [StepOutW-1:0] typed_stop);
        scan_result_t want;
        int           gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 64)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, GAP_MAX);
            if (gap > 0)
            begin
                cand_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        cand_ch.valid     <= 1'b1;
        cand_ch.candidate <= n;
        do
            @(posedge clk);
        while (!cand_ch.ready);
        want = predict_scan(n);
        if (typed)
        begin
            want.verdict = typed_verdict;
            want.stop    = typed_stop;
        end
        pending_q.push_back(want);
        burst_left--;
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: ready follows one of four modes, each drawn at random for a random run
    initial
    begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            case (mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 1) == 1);
                2: res_ch.ready <= ($urandom_range(0, 9) == 0);
                default: res_ch.ready <= ((mode_left % 7) != 0);
            endcase
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d words outstanding",
                         cycle_count, pending_q.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Check each result word against the oldest prediction
    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result word with none expected: verdict %0d", res_ch.verdict);
                mismatches++;
            end
            else
            begin
                want = pending_q.pop_front();
                check_field("verdict", 64'(want.verdict), 64'(res_ch.verdict));
                check_field("stop_step", 64'(want.stop), 64'(res_ch.stop_step));
                check_field("total_bad", want.bad_count, res_ch.total_bad);
                check_field("earliest_bad", want.first_bad, res_ch.earliest_bad);
                check_field("largest_stop", 64'(want.top_stop), 64'(res_ch.largest_stop));
                check_field("total_skip_headroom", want.headroom_count,
                            res_ch.total_skip_headroom);
                check_field("total_skip_length", want.length_count, res_ch.total_skip_length);
                words_checked++;
                if (res_ch.verdict <= 3'd4)
                    verdict_hits[res_ch.verdict]++;
            end
        end
    end

    // Main sequence: reset, directed table, random words, drain
    initial
    begin
        logic [CandW-1:0] n;
        int               sel;
        int               j;
        mismatches     = 0;
        words_checked  = 0;
        burst_left     = 0;
        verdict_hits   = '{default: 0};
        tally_bad      = '0;
        first_bad_n    = '0;
        max_stop       = '0;
        tally_headroom = '0;
        tally_length   = '0;
        build_need_table();
        rst_n = 1'b0;
        cand_ch.valid     <= 1'b0;
        cand_ch.candidate <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < TABLE_ROWS; i++)
            send_word(scan_table[i].n, scan_table[i].typed, scan_table[i].verdict,
                      scan_table[i].stop);

        // Random words, weighted towards long climbs, values near the top of the range and small values
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            n = {$urandom, $urandom};
            sel = $urandom_range(0, 99);
            if (sel < 40)
            begin
                // keep full random value
            end
            else if (sel < 62)
            begin
                j = $urandom_range(4, 63);
                n = n | ((64'd1 << j) - 64'd1);
            end
            else if (sel < 72)
            begin
                n = 64'($urandom_range(0, 1000));
            end
            else if (sel < 84)
            begin
                j = $urandom_range(1, 40);
                n = n | ~(64'hFFFF_FFFF_FFFF_FFFF >> j);
            end
            else
            begin
                j = $urandom_range(1, 62);
                n = n >> j;
            end
            send_word(n, 1'b0, ccss_pkg::VERDICT_HOLDS, '0);
        end
        cand_ch.valid <= 1'b0;

        // Drain outstanding results, then hold a little to catch stray words
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d result words in %0d cycles, longest stop step %0d",
                 words_checked, cycle_count, max_stop);
        $display("verdicts: %0d hold, %0d counterexample, %0d headroom, %0d length, %0d below two",
                 verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3],
                 verdict_hits[4]);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ccss_pkg.sv
rtl/ccss_if.sv
rtl/ccss_front.sv
rtl/ccss_queue.sv
rtl/ccss_walker.sv
rtl/ccss_tally.sv
rtl/collatz_coefficient_stopping_scan.sv
test/collatz_coefficient_stopping_scan_tb.sv
